/* rtl/assert_macros.svh */
// Assertion macros shared by the encoder RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Check that a property holds at every clock edge outside reset.
`define AHFE_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check that a condition never holds at a clock edge outside reset.
`define AHFE_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define AHFE_ASSERT(lbl, clk, rst_n, prop, msg)
`define AHFE_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

/* rtl/ahfe_pkg.sv */
// Types, constants and helpers for the ASCII hex frame encoder.
package ahfe_pkg;

    localparam logic ACT_START = 1'b0;
    localparam logic ACT_DATA  = 1'b1;

    localparam logic [7:0] CSUM_BIAS    = 8'h55;
    localparam logic [7:0] CHAR_COLON   = 8'h3A;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_A       = 8'h41;
    localparam logic [3:0] NIBBLE_TEN   = 4'd10;

    typedef struct packed {
        logic       action;
        logic [7:0] frame_length;
        logic [7:0] byte_value;
    } t_in_word;

    typedef struct packed {
        logic [7:0] out_char;
        logic       last_of_run;
    } t_out_word;

    // One word of work for the back end: optional colon, one hex byte,
    // optional trailer (checksum byte and newline).
    typedef struct packed {
        logic       head;
        logic [7:0] hex_val;
        logic       trailer;
        logic [7:0] sum_val;
    } t_cmd;

    typedef enum logic [2:0] {
        PH_START,
        PH_COLON,
        PH_HEX_HI,
        PH_HEX_LO,
        PH_SUM_HI,
        PH_SUM_LO,
        PH_NEWLINE
    } t_phase;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] res;
        if (nib < NIBBLE_TEN) begin
            res = CHAR_ZERO + {4'd0, nib};
        end else begin
            res = CHAR_A + {4'd0, nib - NIBBLE_TEN};
        end
        return res;
    endfunction

endpackage

/* rtl/ahfe_front.sv */
// Front end: accepts input words, tracks the open frame and builds commands.
module ahfe_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  ahfe_pkg::t_in_word i_word,
    output logic              o_stall,
    input  logic              i_full,
    output logic              o_push,
    output ahfe_pkg::t_cmd    o_cmd
);
    import ahfe_pkg::*;

    logic [7:0] r_remaining, n_remaining;
    logic [7:0] r_checksum, n_checksum;
    logic       r_open, n_open;
    logic       accept;
    logic [7:0] sum_next;

    assign o_stall  = i_full;
    assign accept   = i_valid && !i_full;
    assign sum_next = r_checksum - i_word.byte_value;

    always_comb begin
        n_remaining = r_remaining;
        n_checksum  = r_checksum;
        n_open      = r_open;
        o_push      = 1'b0;
        o_cmd       = '0;
        if (accept) begin
            if (i_word.action == ACT_START) begin
                n_checksum    = '0;
                n_remaining   = i_word.frame_length;
                n_open        = (i_word.frame_length != 8'd0);
                o_push        = 1'b1;
                o_cmd.head    = 1'b1;
                o_cmd.hex_val = i_word.frame_length;
                o_cmd.trailer = (i_word.frame_length == 8'd0);
                o_cmd.sum_val = CSUM_BIAS;
            end else if (r_open) begin
                // drop data words that arrive with no frame open
                n_checksum    = sum_next;
                n_remaining   = r_remaining - 8'd1;
                n_open        = (r_remaining != 8'd1);
                o_push        = 1'b1;
                o_cmd.head    = 1'b0;
                o_cmd.hex_val = i_word.byte_value;
                o_cmd.trailer = (r_remaining == 8'd1);
                o_cmd.sum_val = sum_next + CSUM_BIAS;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_remaining <= '0;
            r_checksum  <= '0;
            r_open      <= 1'b0;
        end else begin
            r_remaining <= n_remaining;
            r_checksum  <= n_checksum;
            r_open      <= n_open;
        end
    end

endmodule

/* rtl/ahfe_queue.sv */
// Command queue between front and back end.
`include "assert_macros.svh"
module ahfe_queue #(
    parameter int DEPTH = 2
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  ahfe_pkg::t_cmd i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output ahfe_pkg::t_cmd o_cmd
);
    import ahfe_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == FULL_CNT);
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    `AHFE_ASSERT_NEVER(a_no_overflow, i_clk, i_rst_n, i_push && o_full, "push into full queue")
    `AHFE_ASSERT_NEVER(a_no_underflow, i_clk, i_rst_n, i_pop && !o_valid, "pop from empty queue")
    `AHFE_ASSERT(a_count_range, i_clk, i_rst_n, r_count <= FULL_CNT, "queue count out of range")

endmodule

/* rtl/ahfe_back.sv */
// Back end: expands each command into ASCII characters behind an output register.
`include "assert_macros.svh"
module ahfe_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cmd_valid,
    input  ahfe_pkg::t_cmd      i_cmd,
    output logic                o_pop,
    output logic                o_valid,
    output ahfe_pkg::t_out_word o_word,
    input  logic                i_stall
);
    import ahfe_pkg::*;

    t_phase     r_phase, n_phase;
    t_phase     eff_phase;
    logic       r_out_valid;
    t_out_word  r_out_word;
    logic       advance;
    logic       is_last;
    logic [7:0] next_char;

    assign o_valid = r_out_valid;
    assign o_word  = r_out_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_START;
        end else begin
            r_phase <= n_phase;
        end
    end

    always_comb begin
        eff_phase = r_phase;
        if (r_phase == PH_START) begin
            eff_phase = i_cmd.head ? PH_COLON : PH_HEX_HI;
        end
        advance   = i_cmd_valid && (!r_out_valid || !i_stall);
        is_last   = 1'b0;
        next_char = CHAR_COLON;
        n_phase   = r_phase;
        o_pop     = 1'b0;
        unique case (eff_phase)
            PH_COLON: begin
                next_char = CHAR_COLON;
            end
            PH_HEX_HI: begin
                next_char = hex_char(i_cmd.hex_val[7:4]);
            end
            PH_HEX_LO: begin
                next_char = hex_char(i_cmd.hex_val[3:0]);
                is_last   = !i_cmd.trailer;
            end
            PH_SUM_HI: begin
                next_char = hex_char(i_cmd.sum_val[7:4]);
            end
            PH_SUM_LO: begin
                next_char = hex_char(i_cmd.sum_val[3:0]);
            end
            PH_NEWLINE: begin
                next_char = CHAR_NEWLINE;
                is_last   = 1'b1;
            end
            default: begin
                next_char = CHAR_COLON;
            end
        endcase
        if (advance) begin
            if (is_last) begin
                n_phase = PH_START;
                o_pop   = 1'b1;
            end else begin
                unique case (eff_phase)
                    PH_COLON:  n_phase = PH_HEX_HI;
                    PH_HEX_HI: n_phase = PH_HEX_LO;
                    PH_HEX_LO: n_phase = PH_SUM_HI;
                    PH_SUM_HI: n_phase = PH_SUM_LO;
                    PH_SUM_LO: n_phase = PH_NEWLINE;
                    default:   n_phase = PH_START;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_word.out_char    <= next_char;
            r_out_word.last_of_run <= is_last;
        end
    end

    `AHFE_ASSERT(a_pop_has_cmd, i_clk, i_rst_n, o_pop |-> i_cmd_valid, "pop without command")
    `AHFE_ASSERT(a_pop_marks_last, i_clk, i_rst_n, o_pop |=> (r_out_valid && r_out_word.last_of_run), "pop without last char")
    `AHFE_ASSERT(a_newline_last, i_clk, i_rst_n, (r_out_valid && (r_out_word.out_char == CHAR_NEWLINE)) |-> r_out_word.last_of_run, "newline not last")

endmodule

/* rtl/ascii_hex_frame_encoder_unit.sv */
// Top level of the ASCII hex frame encoder.
//
// Input channel: i_in_valid / o_in_stall carry one word (action, frame_length,
// byte_value). A start word emits ':' and the length as two upper-case hex
// digits; a data word emits its byte as two hex digits. After the last byte
// of a frame the same word also emits the checksum plus 0x55 as two hex
// digits and a newline. An empty frame closes at once. Data words with no
// frame open are dropped without output.
// Output channel: o_out_valid / i_out_stall carry one character per word,
// with last_of_run set on the final character caused by an input word.
// Each character passes the command queue and the output register after
// its input word is taken; one character per cycle leaves while the receiver
// does not stall, set by the single serializer in the back end. A data word
// yields 2 characters, a start 3, the closing data word 5, an empty start 6.
// A QUEUE_DEPTH command queue decouples the front end from the serializer;
// the input stalls only when it is full.
// Reset clears the frame state, the queue and the output valid flag.
// While the receiver stalls, the output word holds and the queue fills.
module ascii_hex_frame_encoder_unit #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  ahfe_pkg::t_in_word  i_in_word,
    output logic                o_in_stall,
    output logic                o_out_valid,
    output ahfe_pkg::t_out_word o_out_word,
    input  logic                i_out_stall
);
    import ahfe_pkg::*;

    // front end to queue
    logic push;
    t_cmd push_cmd;
    logic q_full;

    // queue to back end
    logic q_valid;
    t_cmd q_cmd;
    logic pop;

    // Classify words and keep frame length and checksum.
    ahfe_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .i_word  (i_in_word),
        .o_stall (o_in_stall),
        .i_full  (q_full),
        .o_push  (push),
        .o_cmd   (push_cmd)
    );

    // Hold pending commands so a stalled receiver does not block intake.
    ahfe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    // Expand commands into characters, one per cycle while a command waits and the receiver does not stall.
    ahfe_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .i_cmd       (q_cmd),
        .o_pop       (pop),
        .o_valid     (o_out_valid),
        .o_word      (o_out_word),
        .i_stall     (i_out_stall)
    );

endmodule

/* tb/tb_ascii_hex_frame_encoder_unit.sv */
// Self-checking testbench for the ASCII hex frame encoder: directed and random frames.
`timescale 1ns / 1ps

module tb_ascii_hex_frame_encoder_unit;
    import ahfe_pkg::*;

    localparam int WORD_TARGET  = 400;
    localparam int DRAIN_CYCLES = 24;
    localparam int LIMIT_CYCLES = 500000;
    localparam int REPORT_MAX   = 10;

    // Receive-side stall patterns.
    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_RANDOM,
        STALL_PERIODIC,
        STALL_HEAVY
    } t_stall_mode;

    // Predicts the characters of each line and checks them in order.
    class hex_line_scoreboard;
        logic [7:0] bytes_left;
        logic [7:0] line_sum;
        logic       line_open;
        logic [7:0] run_chars[$];
        t_out_word  pending_chars[$];
        int         mismatches;
        int         chars_checked;
        int         words_dropped;
        int         lines_closed;

        function new();
            bytes_left    = '0;
            line_sum      = '0;
            line_open     = 1'b0;
            mismatches    = 0;
            chars_checked = 0;
            words_dropped = 0;
            lines_closed  = 0;
        endfunction

        function logic [7:0] ascii_nibble(logic [3:0] nib);
            if (nib < NIBBLE_TEN) begin
                return CHAR_ZERO + {4'd0, nib};
            end
            return CHAR_A + {4'd0, nib - NIBBLE_TEN};
        endfunction

        function void add_hex(logic [7:0] val);
            run_chars.push_back(ascii_nibble(val[7:4]));
            run_chars.push_back(ascii_nibble(val[3:0]));
        endfunction

        // Append biased checksum and newline, then close the line.
        function void close_line();
            add_hex(line_sum + CSUM_BIAS);
            run_chars.push_back(CHAR_NEWLINE);
            line_open  = 1'b0;
            bytes_left = '0;
            lines_closed++;
        endfunction

        // Note one accepted input word and queue the characters it causes.
        function void note_word(t_in_word w);
            t_out_word ow;
            run_chars.delete();
            if (w.action == ACT_START) begin
                // A new start drops any open line without its trailer.
                line_sum   = '0;
                bytes_left = w.frame_length;
                line_open  = 1'b1;
                run_chars.push_back(CHAR_COLON);
                add_hex(w.frame_length);
                if (bytes_left == 8'd0) begin
                    close_line();
                end
            end else begin
                if (!line_open) begin
                    words_dropped++;
                    return;
                end
                add_hex(w.byte_value);
                line_sum   = line_sum - w.byte_value;
                bytes_left = bytes_left - 8'd1;
                if (bytes_left == 8'd0) begin
                    close_line();
                end
            end
            foreach (run_chars[i]) begin
                ow.out_char    = run_chars[i];
                ow.last_of_run = (i == run_chars.size() - 1);
                pending_chars.push_back(ow);
            end
        endfunction

        // Compare one accepted output word against the oldest expectation.
        function void check_char(t_out_word got);
            t_out_word want;
            if (pending_chars.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX) begin
                    $display("unexpected word: char %h last %b", got.out_char,
                             got.last_of_run);
                end
                return;
            end
            want = pending_chars.pop_front();
            chars_checked++;
            if (got.out_char !== want.out_char ||
                got.last_of_run !== want.last_of_run) begin
                mismatches++;
                if (mismatches <= REPORT_MAX) begin
                    $display("mismatch at char %0d: expected char %h last %b, %s %h last %b",
                             chars_checked, want.out_char, want.last_of_run,
                             "got char", got.out_char, got.last_of_run);
                end
            end
        endfunction
    endclass

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    t_in_word  i_in_word;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_word o_out_word;
    logic      i_out_stall;

    hex_line_scoreboard board;
    int          cycle_count;
    int          burst_left;
    int          words_sent;
    logic        drv_line_open;
    t_stall_mode stall_mode;
    int          stall_mode_left;
    int          stall_phase;

    ascii_hex_frame_encoder_unit u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_word  (i_in_word),
        .o_in_stall (o_in_stall),
        .o_out_valid(o_out_valid),
        .o_out_word (o_out_word),
        .i_out_stall(i_out_stall)
    );

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    // Watch both channels in one process so the input word is noted before
    // any character it causes can be checked.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                board.note_word(i_in_word);
            end
            if (o_out_valid && !i_out_stall) begin
                board.check_char(o_out_word);
            end
        end
    end

    // Hard limit on run length.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d characters still expected",
                     cycle_count, board.pending_chars.size());
            $display("status: fail");
            $finish;
        end
    end

    // Receiver back-pressure: switch among stall patterns every so often,
    // including stretches with no stall at all.
    always @(posedge i_clk) begin
        if (stall_mode_left == 0) begin
            stall_mode      <= t_stall_mode'($urandom_range(0, 3));
            stall_mode_left <= $urandom_range(20, 120);
            i_out_stall     <= 1'b0;
        end else begin
            stall_mode_left <= stall_mode_left - 1;
            stall_phase     <= (stall_phase == 4) ? 0 : stall_phase + 1;
            case (stall_mode)
                STALL_NONE: begin
                    i_out_stall <= 1'b0;
                end
                STALL_RANDOM: begin
                    i_out_stall <= ($urandom_range(0, 99) < 35);
                end
                STALL_PERIODIC: begin
                    i_out_stall <= (stall_phase < 2);
                end
                default: begin
                    i_out_stall <= ($urandom_range(0, 99) < 80);
                end
            endcase
        end
    end

    // Present one word, possibly after an idle gap when the current burst runs
    // out, and hold it until the block takes it.
    task automatic send_word(input t_in_word w);
        int gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
            burst_left = $urandom_range(1, 40);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                i_in_word  <= t_in_word'($urandom);
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic send_start(input logic [7:0] len, input logic [7:0] junk);
        t_in_word w;
        w.action       = ACT_START;
        w.frame_length = len;
        w.byte_value   = junk;
        send_word(w);
    endtask

    task automatic send_data(input logic [7:0] val, input logic [7:0] junk);
        t_in_word w;
        w.action       = ACT_DATA;
        w.frame_length = junk;
        w.byte_value   = val;
        send_word(w);
    endtask

    initial begin
        logic [7:0] len;
        int         pick;
        int         nsend;
        logic       abandon;

        board           = new();
        cycle_count     = 0;
        burst_left      = 0;
        words_sent      = 0;
        drv_line_open   = 1'b0;
        stall_mode      = STALL_NONE;
        stall_mode_left = 0;
        stall_phase     = 0;
        i_rst_n         = 1'b0;
        i_in_valid      = 1'b0;
        i_in_word       = '0;
        i_out_stall     = 1'b0;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: data with no line open, empty frame, longest length
        // abandoned by a new start, extreme bytes, bytes after a closed line,
        // every hex digit, and checksum wrap.
        send_data(8'hFF, 8'hFF);
        send_start(8'h00, 8'hFF);
        send_start(8'hFF, 8'hAA);
        send_data(8'h00, 8'h00);
        send_data(8'hFF, 8'hFF);
        send_start(8'h01, 8'h55);
        send_data(8'h00, 8'h7E);
        send_data(8'h12, 8'h34);
        send_start(8'h02, 8'h00);
        send_data(8'hFF, 8'h80);
        send_data(8'h01, 8'h01);
        send_start(8'h08, 8'hC3);
        send_data(8'h01, 8'h00);
        send_data(8'h23, 8'hFF);
        send_data(8'h45, 8'h00);
        send_data(8'h67, 8'hFF);
        send_data(8'h89, 8'h00);
        send_data(8'hAB, 8'hFF);
        send_data(8'hCD, 8'h00);
        send_data(8'hEF, 8'hFF);
        send_start(8'hAB, 8'h00);
        send_data(8'hFE, 8'h3C);
        send_start(8'h01, 8'hFF);
        send_data(8'hFF, 8'h00);

        // Random: mostly whole frames with random bytes, some abandoned by a
        // new start, some stray data between lines.
        while (words_sent < WORD_TARGET) begin
            pick = $urandom_range(0, 99);
            if (pick < 8 && !drv_line_open) begin
                // Drop: no line is open, so this word causes nothing.
                send_data(8'($urandom), 8'($urandom));
                words_sent += 1;
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 10) begin
                    len = 8'd0;
                end else if (pick < 75) begin
                    len = 8'($urandom_range(1, 6));
                end else if (pick < 97) begin
                    len = 8'($urandom_range(7, 24));
                end else begin
                    len = 8'($urandom_range(100, 255));
                end
                abandon = (len != 8'd0) && ($urandom_range(0, 99) < 10);
                nsend   = abandon ? int'($urandom_range(0, len - 1)) : int'(len);
                send_start(len, 8'($urandom));
                repeat (nsend) send_data(8'($urandom), 8'($urandom));
                words_sent   += 1 + nsend;
                drv_line_open = abandon;
            end
        end

        i_in_valid <= 1'b0;
        // Let the last accepted word be noted before waiting on the drain.
        @(posedge i_clk);
        while (board.pending_chars.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d random words after the directed set, %0d data words dropped",
                 words_sent, board.words_dropped);
        $display("%0d lines closed, %0d characters checked, %0d mismatches",
                 board.lines_closed, board.chars_checked, board.mismatches);
        if (board.mismatches == 0 && board.pending_chars.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
